@@ rtl/delta_timer_queue_defines.svh @@
// Assertion macros shared by the delta timer queue RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef DELTA_TIMER_QUEUE_DEFINES_SVH
`define DELTA_TIMER_QUEUE_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define DTQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dtq_pkg.sv @@
// Shared types, constants and the control store of the delta timer queue.
// No dependencies; every other file but delta_timer_queue_defines.svh imports this package.
package dtq_pkg;

  // Sizing of the queue.
  localparam int QUEUE_DEPTH = 8;
  localparam int DELAY_WIDTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed widths of the item fields.
  localparam int ID_W     = 3;
  localparam int DLY_IN_W = 16;

  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [DELAY_WIDTH-1:0] delta_t;
  typedef logic [ID_W-1:0]        id_t;
  typedef logic [DLY_IN_W-1:0]    dly_in_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_WOKEN  = 2'd2
  } kind_t;

  // Control store addresses.
  typedef logic [3:0] step_t;
  localparam step_t ST_IDLE  = 4'd0;
  localparam step_t ST_DISP  = 4'd1;
  localparam step_t ST_CHK   = 4'd2;
  localparam step_t ST_WALK  = 4'd3;
  localparam step_t ST_PLACE = 4'd4;
  localparam step_t ST_REJ   = 4'd5;
  localparam step_t ST_TICK  = 4'd6;
  localparam step_t ST_WAKE  = 4'd7;
  localparam step_t ST_FLUSH = 4'd8;

  // Jump conditions.
  typedef enum logic [2:0] {
    J_NONE     = 3'd0,
    J_ACCEPT   = 3'd1,
    J_TICK     = 3'd2,
    J_DUP      = 3'd3,
    J_WALK_END = 3'd4,
    J_EMPTY    = 3'd5,
    J_WAKE_END = 3'd6,
    J_ALWAYS   = 3'd7
  } jump_t;

  // Datapath operations.
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_LOAD  = 3'd1,
    OP_ADV   = 3'd2,
    OP_PLACE = 3'd3,
    OP_DEC   = 3'd4,
    OP_WAKE  = 3'd5
  } op_t;

  // Result emission selects.
  typedef enum logic [1:0] {
    EM_NONE   = 2'd0,
    EM_ACCEPT = 2'd1,
    EM_REJECT = 2'd2,
    EM_PEND   = 2'd3
  } emit_t;

  // One control word. The operation and emission fire when the jump outcome
  // equals op_on_taken. An untaken jump stays on the step when hold is set.
  typedef struct packed {
    jump_t jump;
    step_t target;
    logic  hold;
    logic  op_on_taken;
    op_t   op;
    emit_t emit;
    logic  last;
  } ctrl_t;

  // Command from the sequencer to the datapath.
  typedef struct packed {
    logic  fire;
    op_t   op;
    emit_t emit;
    logic  last;
  } dtq_cmd_t;

  // Status from the datapath used by the jump conditions.
  typedef struct packed {
    logic tick;
    logic dup;
    logic walk_end;
    logic empty;
    logic wake_end;
  } dtq_flags_t;

  // Result request from the datapath to the output register.
  typedef struct packed {
    logic  valid;
    kind_t kind;
    id_t   id;
    logic  last;
  } dtq_emit_req_t;

  // Builds one control word.
  function automatic ctrl_t cw(input jump_t j, input step_t t, input logic h,
                               input logic ot, input op_t o, input emit_t e,
                               input logic l);
    ctrl_t w;
    w = '{jump: j, target: t, hold: h, op_on_taken: ot, op: o, emit: e, last: l};
    return w;
  endfunction

  // Microprogram. Insert: dispatch, duplicate check, walk, place (or reject).
  // Tick: lower head, wake leading zero entries, flush the held wake.
  function automatic ctrl_t dtq_ucode(input step_t a);
    ctrl_t w;
    case (a)
      ST_IDLE:  w = cw(J_ACCEPT,   ST_DISP,  1'b1, 1'b1, OP_LOAD,  EM_NONE,   1'b0);
      ST_DISP:  w = cw(J_TICK,     ST_TICK,  1'b0, 1'b0, OP_NONE,  EM_NONE,   1'b0);
      ST_CHK:   w = cw(J_DUP,      ST_REJ,   1'b0, 1'b0, OP_NONE,  EM_NONE,   1'b0);
      ST_WALK:  w = cw(J_WALK_END, ST_PLACE, 1'b1, 1'b0, OP_ADV,   EM_NONE,   1'b0);
      ST_PLACE: w = cw(J_ALWAYS,   ST_IDLE,  1'b0, 1'b1, OP_PLACE, EM_ACCEPT, 1'b1);
      ST_REJ:   w = cw(J_ALWAYS,   ST_IDLE,  1'b0, 1'b1, OP_NONE,  EM_REJECT, 1'b1);
      ST_TICK:  w = cw(J_EMPTY,    ST_IDLE,  1'b0, 1'b0, OP_DEC,   EM_NONE,   1'b0);
      ST_WAKE:  w = cw(J_WAKE_END, ST_FLUSH, 1'b1, 1'b0, OP_WAKE,  EM_PEND,   1'b0);
      ST_FLUSH: w = cw(J_ALWAYS,   ST_IDLE,  1'b0, 1'b1, OP_NONE,  EM_PEND,   1'b1);
      default:  w = cw(J_ALWAYS,   ST_IDLE,  1'b0, 1'b1, OP_NONE,  EM_NONE,   1'b0);
    endcase
    return w;
  endfunction

  // Saturates an input delay to the delta width.
  function automatic delta_t sat_delay(input dly_in_t d);
    dly_in_t hi;
    hi = d >> DELAY_WIDTH;
    return (hi != '0) ? '1 : delta_t'(d);
  endfunction

endpackage

@@ rtl/dtq_if.sv @@
// Valid/ready channel interfaces for the delta timer queue.
// Depends on dtq_pkg for the field types.
interface dtq_in_if
  import dtq_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    mode;
  id_t     sleeper_id;
  dly_in_t delay;

  modport source (output valid, output mode, output sleeper_id, output delay,
                  input ready);
  modport sink   (input valid, input mode, input sleeper_id, input delay,
                  output ready);
endinterface

interface dtq_out_if
  import dtq_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  id_t        woken_id;
  logic       last;

  modport source (output valid, output kind, output woken_id, output last,
                  input ready);
  modport sink   (input valid, input kind, input woken_id, input last,
                  output ready);
endinterface

@@ rtl/dtq_seq.sv @@
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on dtq_pkg and delta_timer_queue_defines.svh.
`include "delta_timer_queue_defines.svh"

module dtq_seq
  import dtq_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  dtq_flags_t flags,
  input  logic       stall,
  output dtq_cmd_t   cmd,
  output logic       idle
);

  step_t upc_r;
  step_t upc_nxt;
  ctrl_t word;
  logic  taken;

  // Fetch the control word of the current step.
  assign word = dtq_ucode(upc_r);

  // Evaluate the jump condition.
  always_comb begin
    case (word.jump)
      J_NONE:     taken = 1'b0;
      J_ACCEPT:   taken = in_valid;
      J_TICK:     taken = flags.tick;
      J_DUP:      taken = flags.dup;
      J_WALK_END: taken = flags.walk_end;
      J_EMPTY:    taken = flags.empty;
      J_WAKE_END: taken = flags.wake_end;
      J_ALWAYS:   taken = 1'b1;
      default:    taken = 1'b0;
    endcase
  end

  // Command to the datapath.
  always_comb begin
    cmd.fire = (taken == word.op_on_taken);
    cmd.op   = word.op;
    cmd.emit = word.emit;
    cmd.last = word.last;
  end

  assign idle = (upc_r == ST_IDLE);

  // Next step: hold on a stall, else jump, stay or fall through.
  always_comb begin
    if (stall) begin
      upc_nxt = upc_r;
    end else if (taken) begin
      upc_nxt = word.target;
    end else if (word.hold) begin
      upc_nxt = upc_r;
    end else begin
      upc_nxt = upc_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  `DTQ_ASSERT_NEXT(a_stall_holds_step, stall, $stable(upc_r), "step moved during a stall")
  `DTQ_ASSERT_NEXT(a_accept_dispatches, idle && in_valid, upc_r == ST_DISP,
                   "accepted item did not reach dispatch")

endmodule

@@ rtl/dtq_dp.sv @@
// Datapath of the delta timer queue: delta list storage, walk registers and
// result selection. Depends on dtq_pkg and delta_timer_queue_defines.svh.
`include "delta_timer_queue_defines.svh"

module dtq_dp
  import dtq_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_mode,
  input  id_t           in_sleeper_id,
  input  dly_in_t       in_delay,
  input  dtq_cmd_t      cmd,
  input  logic          stall,
  output dtq_flags_t    flags,
  output dtq_emit_req_t em
);

  // Delta list storage.
  delta_t                 delta_r [QUEUE_DEPTH];
  idx_t                   next_r  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] queued_r;
  idx_t                   head_r;
  logic                   empty_r;
  cnt_t                   cnt_r;

  // Item and walk registers.
  logic   mode_r;
  id_t    id_r;
  delta_t rem_r;
  idx_t   cur_r;
  idx_t   prev_r;
  logic   have_prev_r;
  cnt_t   steps_r;
  idx_t   pend_r;
  logic   pend_v_r;

  idx_t   id_idx;
  logic   id_ok;
  cnt_t   n;
  delta_t cur_delta;
  idx_t   cur_next;
  logic   commit;
  logic   not_end;

  assign id_idx    = idx_t'(id_r);
  assign id_ok     = (32'(id_r) < QUEUE_DEPTH);
  assign n         = empty_r ? '0 : cnt_r;
  assign cur_delta = delta_r[cur_r];
  assign cur_next  = next_r[cur_r];
  assign commit    = cmd.fire && !stall;
  assign not_end   = (steps_r != n);

  // Status for the jump conditions.
  always_comb begin
    flags.tick     = mode_r;
    flags.dup      = !id_ok || queued_r[id_idx];
    flags.walk_end = !not_end || (rem_r <= cur_delta);
    flags.empty    = (n == '0);
    flags.wake_end = (n == '0) || (cur_delta != '0);
  end

  // Result request; a wake is held in pend_r and reported by the next wake or the flush so its last flag is known.
  always_comb begin
    em.valid = 1'b0;
    em.kind  = KIND_ACCEPT;
    em.id    = id_r;
    em.last  = cmd.last;
    case (cmd.emit)
      EM_ACCEPT: begin
        em.valid = cmd.fire;
        em.kind  = KIND_ACCEPT;
      end
      EM_REJECT: begin
        em.valid = cmd.fire;
        em.kind  = KIND_REJECT;
      end
      EM_PEND: begin
        em.valid = cmd.fire && pend_v_r;
        em.kind  = KIND_WOKEN;
        em.id    = id_t'(pend_r);
      end
      default: begin
        em.valid = 1'b0;
      end
    endcase
  end

  // Storage and item payload, no reset.
  always_ff @(posedge clk) begin
    if (commit) begin
      case (cmd.op)
        OP_LOAD: begin
          mode_r <= in_mode;
          id_r   <= in_sleeper_id;
          rem_r  <= sat_delay(in_delay);
        end
        OP_ADV: begin
          rem_r  <= rem_r - cur_delta;
          prev_r <= cur_r;
        end
        OP_PLACE: begin
          if (not_end) begin
            delta_r[cur_r] <= cur_delta - rem_r;
          end
          delta_r[id_idx] <= rem_r;
          next_r[id_idx]  <= not_end ? cur_r : '0;
          if (have_prev_r) begin
            next_r[prev_r] <= id_idx;
          end
        end
        OP_DEC: begin
          if (cur_delta != '0) begin
            delta_r[cur_r] <= cur_delta - delta_t'(1);
          end
        end
        OP_WAKE: begin
          pend_r <= cur_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state of the list and the walk.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r    <= '0;
      head_r      <= '0;
      empty_r     <= 1'b1;
      cnt_r       <= '0;
      cur_r       <= '0;
      have_prev_r <= 1'b0;
      steps_r     <= '0;
      pend_v_r    <= 1'b0;
    end else if (commit) begin
      case (cmd.op)
        OP_LOAD: begin
          cur_r       <= head_r;
          steps_r     <= '0;
          have_prev_r <= 1'b0;
          pend_v_r    <= 1'b0;
        end
        OP_ADV: begin
          cur_r       <= cur_next;
          steps_r     <= steps_r + cnt_t'(1);
          have_prev_r <= 1'b1;
        end
        OP_PLACE: begin
          if (!have_prev_r) begin
            head_r <= id_idx;
          end
          queued_r[id_idx] <= 1'b1;
          empty_r          <= 1'b0;
          cnt_r            <= cnt_r + cnt_t'(1);
        end
        OP_WAKE: begin
          pend_v_r        <= 1'b1;
          queued_r[cur_r] <= 1'b0;
          cnt_r           <= cnt_r - cnt_t'(1);
          if (cnt_r == cnt_t'(1)) begin
            empty_r <= 1'b1;
          end else begin
            head_r <= cur_next;
            cur_r  <= cur_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  `DTQ_ASSERT_ALWAYS(a_count_matches, $countones(queued_r) == 32'(cnt_r),
                     "entry count disagrees with queued flags")
  `DTQ_ASSERT_ALWAYS(a_empty_matches, empty_r == (cnt_r == '0),
                     "empty flag disagrees with entry count")

endmodule

@@ rtl/delta_timer_queue.sv @@
// Top level of the delta timer queue: sequencer, datapath and output register.
// Depends on dtq_pkg, dtq_in_if, dtq_out_if, dtq_seq and dtq_dp.
//
// Usage: items arrive on in_ch. mode 0 inserts sleeper_id with a delay in
// ticks; mode 1 is one tick. Results leave on out_ch as kind, woken_id and
// last. An insert gives one result (accepted or rejected as a duplicate); a
// tick gives one wake result for each leading entry whose delta reaches zero,
// or none, with last set on the final one.
// One item is handled at a time. in_ch.ready is high only while the
// sequencer waits for an item. An insert takes longer the more entries it
// walks past, and a duplicate ends after the check; a tick takes longer the
// more entries it wakes, and ends early on an empty queue. The list walk
// visits one entry per cycle.
// A result is held in an output register, so the first result appears in the
// cycle after the step that makes it. While out_ch is stalled and the
// register is full, the sequencer holds a step that makes a result.
// Synchronous active-low reset empties the queue and returns to idle.
module delta_timer_queue
  import dtq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dtq_in_if.sink    in_ch,
  dtq_out_if.source out_ch
);

  dtq_cmd_t      cmd;
  dtq_flags_t    flags;
  dtq_emit_req_t em;
  logic          idle;
  logic          out_full;
  logic          stall;
  logic          push;

  logic  out_v_r;
  kind_t out_kind_r;
  id_t   out_id_r;
  logic  out_last_r;

  dtq_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .flags    (flags),
    .stall    (stall),
    .cmd      (cmd),
    .idle     (idle)
  );

  dtq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mode       (in_ch.mode),
    .in_sleeper_id (in_ch.sleeper_id),
    .in_delay      (in_ch.delay),
    .cmd           (cmd),
    .stall         (stall),
    .flags         (flags),
    .em            (em)
  );

  assign in_ch.ready = idle;

  // Output register; a new result may replace one taken in the same cycle.
  assign out_full = out_v_r && !out_ch.ready;
  assign stall    = em.valid && out_full;
  assign push     = em.valid && !out_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r <= em.kind;
      out_id_r   <= em.id;
      out_last_r <= em.last;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.woken_id = out_id_r;
  assign out_ch.last     = out_last_r;

endmodule

@@ tb/sv/delta_timer_queue_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for delta_timer_queue: inserts and ticks drive the
// sleep list, and a scoreboard tracks the expected queue to check each result.
// Depends on dtq_pkg, dtq_in_if, dtq_out_if and the delta_timer_queue RTL.
module delta_timer_queue_test
  import dtq_pkg::*;
();

  localparam bit MODE_INSERT = 1'b0;
  localparam bit MODE_TICK   = 1'b1;
  localparam int RANDOM_ITEMS  = 260;
  localparam int PRESSURE_AT   = 40;
  localparam int PRESSURE_HOLD = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int TIMEOUT_NS    = 2_000_000;

  // One result as the block should report it.
  typedef struct packed {
    kind_t kind;
    id_t   id;
    logic  last;
  } sleep_result_t;

  // Tracks the delta list and the results that are still due.
  class delta_list_scoreboard;
    delta_t        gap_ahead[QUEUE_DEPTH];
    idx_t          next_id[QUEUE_DEPTH];
    bit            queued[QUEUE_DEPTH];
    idx_t          head;
    bit            empty;
    sleep_result_t due_results[$];
    int            errors;
    int            inserts;
    int            rejects;
    int            ticks;
    int            wakes;
    int            results;

    function new();
      foreach (queued[i]) queued[i] = 1'b0;
      head    = '0;
      empty   = 1'b1;
      errors  = 0;
      inserts = 0;
      rejects = 0;
      ticks   = 0;
      wakes   = 0;
      results = 0;
    endfunction

    // Applies one accepted item to the list and queues what it should report.
    function void note_item(bit mode, id_t id, dly_in_t delay);
      int            n;
      int            steps;
      delta_t        rem;
      idx_t          cur;
      idx_t          prev;
      bit            have_prev;
      idx_t          woken[$];
      sleep_result_t r;
      n = 0;
      if (!empty) begin
        foreach (queued[i]) if (queued[i]) n++;
      end
      if (mode == MODE_INSERT) begin
        inserts++;
        if (int'(id) >= QUEUE_DEPTH || queued[id]) begin
          rejects++;
          r = '{kind: KIND_REJECT, id: id, last: 1'b1};
          due_results.push_back(r);
          return;
        end
        // Delays beyond the delta width saturate.
        if ((32'(delay) >> DELAY_WIDTH) != 0) rem = '1;
        else rem = delta_t'(delay);
        // Walk past every entry whose delta is smaller than what remains.
        cur       = head;
        prev      = '0;
        have_prev = 1'b0;
        steps     = 0;
        while (steps < n && rem > gap_ahead[cur]) begin
          rem       = rem - gap_ahead[cur];
          prev      = cur;
          have_prev = 1'b1;
          cur       = next_id[cur];
          steps++;
        end
        if (steps < n) begin
          gap_ahead[cur] = gap_ahead[cur] - rem;
          next_id[id]    = cur;
        end else begin
          next_id[id] = '0;
        end
        if (have_prev) next_id[prev] = idx_t'(id);
        else head = idx_t'(id);
        gap_ahead[id] = rem;
        queued[id]    = 1'b1;
        empty         = 1'b0;
        r = '{kind: KIND_ACCEPT, id: id, last: 1'b1};
        due_results.push_back(r);
      end else begin
        ticks++;
        if (n == 0) return;
        // A head that is already zero is not lowered again.
        if (gap_ahead[head] != '0) gap_ahead[head] = gap_ahead[head] - 1'b1;
        while (n > 0 && gap_ahead[head] == '0) begin
          woken.push_back(head);
          queued[head] = 1'b0;
          n--;
          if (n == 0) empty = 1'b1;
          else head = next_id[head];
        end
        foreach (woken[i]) begin
          r = '{kind: KIND_WOKEN, id: id_t'(woken[i]), last: (i == woken.size() - 1)};
          due_results.push_back(r);
        end
      end
    endfunction

    // Compares one received result against the oldest one due.
    function void check_result(logic [1:0] kind, id_t id, logic last);
      sleep_result_t exp_r;
      results++;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result kind=%0d id=%0d last=%0d", $time, kind, id, last);
        errors++;
        return;
      end
      exp_r = due_results.pop_front();
      if (exp_r.kind == KIND_WOKEN) wakes++;
      if (kind !== exp_r.kind) begin
        $display("%0t: kind mismatch: expected %0d, actual %0d", $time, exp_r.kind, kind);
        errors++;
      end
      if (id !== exp_r.id) begin
        $display("%0t: id mismatch: expected %0d, actual %0d", $time, exp_r.id, id);
        errors++;
      end
      if (last !== exp_r.last) begin
        $display("%0t: last mismatch: expected %0d, actual %0d", $time, exp_r.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   no_idle;

  delta_list_scoreboard sb;

  dtq_in_if  in_ch();
  dtq_out_if out_ch();

  delta_timer_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Offers one item after a random gap and waits until it is accepted.
  task automatic send_item(input bit mode, input id_t id, input dly_in_t delay);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= mode;
    in_ch.sleeper_id <= id;
    in_ch.delay      <= delay;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_item(mode, id, delay);
  endtask

  // Result side: random stalls, one long hold-off, and a check per result.
  initial begin : result_sink
    int stall;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held && sb.results >= PRESSURE_AT) begin
        stall = PRESSURE_HOLD;
        held  = 1'b1;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      sb.check_result(out_ch.kind, out_ch.woken_id, out_ch.last);
    end
  end

  // Stimulus, end of run and verdict.
  initial begin : stimulus
    int      pct;
    bit      mode;
    dly_in_t delay;
    sb = new();
    no_idle = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.mode       <= MODE_INSERT;
    in_ch.sleeper_id <= '0;
    in_ch.delay      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A tick on an empty queue, a zero delay, and a duplicate id.
    send_item(MODE_TICK, 3'd5, 16'hFFFF);
    send_item(MODE_INSERT, 3'd0, 16'd0);
    send_item(MODE_INSERT, 3'd0, 16'd5);
    // Equal delays: the newer entry goes ahead and the older delta drops to zero.
    send_item(MODE_INSERT, 3'd1, 16'd3);
    send_item(MODE_INSERT, 3'd2, 16'd3);
    send_item(MODE_TICK, 3'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0);
    send_item(MODE_TICK, 3'd0, 16'd0);
    // Fill every slot with the same delay, reject one more, then wake all at once.
    for (int i = 0; i < QUEUE_DEPTH; i++) send_item(MODE_INSERT, id_t'(i), 16'd1);
    send_item(MODE_INSERT, 3'd4, 16'd9);
    send_item(MODE_TICK, 3'd0, 16'd0);
    // Inserts that walk past several entries.
    send_item(MODE_INSERT, 3'd3, 16'd10);
    send_item(MODE_INSERT, 3'd5, 16'd4);
    send_item(MODE_INSERT, 3'd6, 16'd20);
    send_item(MODE_INSERT, 3'd1, 16'd7);

    // Random mix, in chunks that sometimes run without any idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) no_idle = ($urandom_range(0, 2) == 0);
      mode = ($urandom_range(0, 99) < 45);
      pct  = $urandom_range(0, 99);
      if (pct < 70) delay = dly_in_t'($urandom_range(0, 6));
      else if (pct < 95) delay = dly_in_t'($urandom_range(7, 40));
      else delay = dly_in_t'($urandom_range(41, 120));
      send_item(mode, id_t'($urandom_range(0, 7)), delay);
    end
    no_idle = 1'b0;

    // Tick until the list is empty, then park the longest delay at the very end
    // so that it never holds an id during the rest of the run.
    while (!sb.empty) send_item(MODE_TICK, id_t'($urandom_range(0, 7)), 16'd0);
    send_item(MODE_INSERT, 3'd7, 16'hFFFF);
    send_item(MODE_TICK, 3'd0, 16'd0);
    in_ch.valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d inserts (%0d rejected) and %0d ticks.", sb.inserts, sb.rejects,
             sb.ticks);
    $display("Checked %0d results, %0d of them wake-ups.", sb.results, sb.wakes);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("%0t: timeout, %0d results still due", $time, sb.due_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
